// File: src/mvadsr_pkg.sv
package mvadsr_pkg;

  // Opcodes carried in the input tuser field.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_KEY_ON  = 3'd1;
  localparam logic [2:0] OP_KEY_OFF = 3'd2;
  localparam logic [2:0] OP_ADSR1   = 3'd3;
  localparam logic [2:0] OP_ADSR2   = 3'd4;
  localparam logic [2:0] OP_LEVEL   = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;

  // Envelope limits and rate constants.
  localparam logic [14:0] LEVEL_MAX   = 15'h7fff;
  localparam logic [14:0] EXP_KNEE    = 15'h6000;
  localparam logic [4:0]  SHIFT_KNEE  = 5'd11;
  localparam logic [1:0]  GUARD_TICKS = 2'd2;
  localparam logic [3:0]  STEP_DEC    = 4'b1000;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  // Parameters latched at phase entry; step is a signed 4-bit value.
  typedef struct packed {
    logic [14:0] target;
    logic        expo;
    logic        dec;
    logic [4:0]  shift;
    logic [3:0]  step;
  } params_t;

  // Complete state of one voice, held as one memory word.
  typedef struct packed {
    logic [15:0] adsr1;
    logic [15:0] adsr2;
    logic [14:0] level;
    phase_t      phase;
    logic [22:0] rate_wait;
    logic [1:0]  guard;
    params_t     params;
  } voice_rec_t;

endpackage

// File: src/multi_voice_adsr_envelope_unit.sv
// Multi-voice ADSR envelope unit: per-voice state lives in one voice memory.
// The result word is registered in the write state, once the output is free; each
// input word passes the read, compute and write-back sequence on the single port of
// the voice memory, and a new one is accepted only after the last has finished.
// Reset (rst, synchronous, active high) clears the per-voice valid bits at once,
// so every voice reads as all zero in attack phase; no clearing pass is needed.
module multi_voice_adsr_envelope_unit
  import mvadsr_pkg::*;
#(
  parameter int NUM_VOICES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // voice [4:0], data_value [20:5], zero [23:21]
  input  logic [2:0]  s_tuser,   // opcode [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // envelope_level [14:0], envelope_phase [16:15],
                                 // accepted [17], zero [23:18]
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_WRITE
  } state_t;

  state_t state;

  // Latched item.
  logic [2:0]    op_q;
  logic [VW-1:0] addr_q;
  logic [15:0]   data_q;
  logic          oob_q;

  // Voice memory and its valid bits.
  voice_rec_t    voice_mem [NUM_VOICES];
  logic          vld [NUM_VOICES];
  voice_rec_t    rd_q;
  logic          rd_vld_q;

  // Compute stage registers.
  voice_rec_t    cur_q;
  logic signed [15:0] step_q;
  logic signed [31:0] prod_q;
  logic [22:0]   rwbase_q;

  // Updated voice record written back to the memory.
  voice_rec_t    nxt_rec;

  // Output fields.
  logic [14:0]   out_level;
  logic [1:0]    out_phase;
  logic          out_acc;

  logic          in_accept;
  logic [4:0]    in_voice;
  logic [VW-1:0] in_addr;
  logic          mem_we;
  logic          out_free;

  assign in_voice  = s_tdata[4:0];
  assign in_addr   = VW'(in_voice);
  assign s_tready  = (state == S_IDLE) && !rst;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign mem_we    = (state == S_WRITE) && out_free && !oob_q;

  // Parameters of a phase taken from the stored ADSR words.
  function automatic params_t phase_entry(input logic [15:0] a1, input logic [15:0] a2,
                                          input phase_t ph);
    params_t     p;
    logic [15:0] t;
    p = '0;
    t = 16'({1'b0, a1[3:0]} + 5'd1) << SHIFT_KNEE;
    unique case (ph)
      PH_ATTACK: begin
        p.target = LEVEL_MAX;
        p.expo   = a1[15];
        p.dec    = 1'b0;
        p.shift  = a1[14:10];
        p.step   = 4'd7 - {2'b00, a1[9:8]};
      end
      PH_DECAY: begin
        p.target = t[15] ? LEVEL_MAX : t[14:0];
        p.expo   = 1'b1;
        p.dec    = 1'b1;
        p.shift  = {1'b0, a1[7:4]};
        p.step   = STEP_DEC;
      end
      PH_SUSTAIN: begin
        p.target = '0;
        p.expo   = a2[15];
        p.dec    = a2[14];
        p.shift  = a2[12:8];
        p.step   = a2[14] ? (STEP_DEC + {2'b00, a2[7:6]}) : (4'd7 - {2'b00, a2[7:6]});
      end
      default: begin
        p.target = '0;
        p.expo   = a2[5];
        p.dec    = 1'b1;
        p.shift  = a2[4:0];
        p.step   = STEP_DEC;
      end
    endcase
    return p;
  endfunction

  // Read and write of the voice memory.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_q <= voice_mem[in_addr];
    end
    if (mem_we) begin
      voice_mem[addr_q] <= nxt_rec;
    end
  end

  // Valid bits: a voice never written reads as its reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        vld[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        rd_vld_q <= vld[in_addr];
      end
      if (mem_we) begin
        vld[addr_q] <= 1'b1;
      end
    end
  end

  // First compute stage: shifted step, scaled product and new rate wait.
  voice_rec_t         cur;
  logic [4:0]         sh;
  logic [3:0]         lsh;
  logic signed [15:0] step_sh;
  logic [22:0]        rwbase;

  assign cur     = rd_vld_q ? rd_q : '0;
  assign sh      = cur.params.shift;
  assign lsh     = (sh < SHIFT_KNEE) ? 4'(SHIFT_KNEE - sh) : 4'd0;
  assign step_sh = $signed({{12{cur.params.step[3]}}, cur.params.step}) <<< lsh;
  assign rwbase  = (sh > SHIFT_KNEE) ? (23'd1 << (sh - SHIFT_KNEE)) : 23'd1;

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      cur_q    <= cur;
      step_q   <= step_sh;
      prod_q   <= step_sh * $signed({1'b0, cur.level});
      rwbase_q <= rwbase;
    end
  end

  // Second stage: scale toward zero, add, clamp and check the phase target.
  logic signed [31:0] prod_div;
  logic signed [17:0] step_eff;
  logic signed [17:0] env;
  logic [14:0]        lvl_new;
  logic               reached;
  params_t            p_cur;

  assign p_cur    = cur_q.params;
  assign prod_div = prod_q[31] ? ((prod_q + 32'sd32767) >>> 15) : (prod_q >>> 15);
  assign step_eff = (p_cur.expo && p_cur.dec) ? $signed(prod_div[17:0])
                                               : 18'(step_q);
  assign env      = $signed({3'b000, cur_q.level}) + step_eff;
  assign lvl_new  = env[17] ? 15'd0 :
                    (env > $signed({3'b000, LEVEL_MAX})) ? LEVEL_MAX : env[14:0];
  assign reached  = p_cur.dec ? (lvl_new <= p_cur.target) : (lvl_new >= p_cur.target);

  logic       acc;
  phase_t     key_ph;
  phase_t     adv_ph;

  assign key_ph = (op_q == OP_KEY_ON) ? PH_ATTACK : PH_RELEASE;
  assign adv_ph = (cur_q.phase == PH_ATTACK) ? PH_DECAY : PH_SUSTAIN;

  // Next voice state for the latched opcode.
  always_comb begin
    nxt_rec = cur_q;
    acc     = 1'b1;
    unique case (op_q)
      OP_TICK: begin
        if (cur_q.guard != 2'd0) begin
          nxt_rec.guard = cur_q.guard - 2'd1;
        end
        if (cur_q.rate_wait != 23'd0) begin
          nxt_rec.rate_wait = cur_q.rate_wait - 23'd1;
        end else begin
          nxt_rec.rate_wait = (p_cur.expo && !p_cur.dec && cur_q.level > EXP_KNEE)
                            ? (rwbase_q << 2) : rwbase_q;
          nxt_rec.level = lvl_new;
          if ((cur_q.phase == PH_ATTACK || cur_q.phase == PH_DECAY) && reached) begin
            nxt_rec.phase  = adv_ph;
            nxt_rec.params = phase_entry(cur_q.adsr1, cur_q.adsr2, adv_ph);
          end
        end
      end
      OP_KEY_ON, OP_KEY_OFF: begin
        if (cur_q.guard != 2'd0) begin
          acc = 1'b0;
        end else begin
          nxt_rec.guard     = GUARD_TICKS;
          nxt_rec.phase     = key_ph;
          nxt_rec.params    = phase_entry(cur_q.adsr1, cur_q.adsr2, key_ph);
          nxt_rec.rate_wait = '0;
          if (op_q == OP_KEY_ON) begin
            nxt_rec.level = '0;
          end
        end
      end
      OP_ADSR1: nxt_rec.adsr1 = data_q;
      OP_ADSR2: nxt_rec.adsr2 = data_q;
      OP_LEVEL: nxt_rec.level = data_q[15] ? LEVEL_MAX : data_q[14:0];
      default: begin
        // Read and the spare opcode leave the voice unchanged.
      end
    endcase
  end

  // Sequencer and output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The write state loads a new word itself; elsewhere a taken word is dropped.
      if (m_tready && state != S_WRITE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_q   <= s_tuser;
            addr_q <= in_addr;
            data_q <= s_tdata[20:5];
            oob_q  <= !(32'(in_voice) < NUM_VOICES);
            state  <= S_CALC;
          end
        end
        S_CALC: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_level <= oob_q ? 15'd0 : nxt_rec.level;
            out_phase <= oob_q ? 2'd0 : nxt_rec.phase;
            out_acc   <= oob_q ? 1'b0 : acc;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'd0, out_acc, out_phase, out_level};

endmodule
